FILE: src/fixed_step_time_bank_macros.svh
// Assertion macros shared by the assertions of the fixed step time bank checker.
`ifndef FIXED_STEP_TIME_BANK_MACROS_SVH
`define FIXED_STEP_TIME_BANK_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define FSTB_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define FSTB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/fstb_pkg.sv
// Shared widths, register indexes, microcode types and control store for the time bank.
package fstb_pkg;

  // Field and register widths.
  localparam int FRAME_W = 24;
  localparam int STEP_W  = 20;
  localparam int MAXS_W  = 8;
  localparam int TOL_W   = 7;
  localparam int COUNT_W = 8;
  localparam int ALPHA_W = 16;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = STEP_W;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_TICKS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_STEPS  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SNAP_TOL   = 2'd2;

  // Register reset values.
  localparam logic [STEP_W-1:0] STEP_TICKS_RESET = 20'd16667;
  localparam logic [MAXS_W-1:0] MAX_STEPS_RESET  = 8'd8;
  localparam logic [TOL_W-1:0]  SNAP_TOL_RESET   = 7'd38;

  // Serial divider sizing: numerator bits, remainder and divisor bits, iteration counts.
  localparam int DIV_NUM_W = 26;
  localparam int DIV_DEN_W = STEP_W + 1;
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_ITERS_LONG  = 5'd26;
  localparam logic [DIV_CNT_W-1:0] DIV_ITERS_ALPHA = 5'd16;

  // Divider control and status between the sequencer and the divider.
  typedef struct packed {
    logic                 load;
    logic [DIV_CNT_W-1:0] iters;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic last;
  } div_stat_t;

  // Microcode.
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_TAKE = 4'd0;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_TAKE,
    OP_DIV_ROUND,
    OP_ITER,
    OP_SNAP_PREP,
    OP_ACC,
    OP_CLAMP,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_NO_INPUT,
    HOLD_DIV_BUSY,
    HOLD_OUT_BUSY
  } hold_t;

  typedef struct packed {
    op_t             op;
    hold_t           hold;
    logic            jump;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  // Control store: one word per step of the per-frame program.
  function automatic ctrl_word_t fstb_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t cw;
    cw = '{op: OP_NOP, hold: HOLD_NONE, jump: 1'b1, target: PC_TAKE};
    unique case (pc)
      4'd0: cw = '{op: OP_TAKE,      hold: HOLD_NO_INPUT, jump: 1'b0, target: PC_TAKE};
      4'd1: cw = '{op: OP_DIV_ROUND, hold: HOLD_NONE,     jump: 1'b0, target: PC_TAKE};
      4'd2: cw = '{op: OP_ITER,      hold: HOLD_DIV_BUSY, jump: 1'b0, target: PC_TAKE};
      4'd3: cw = '{op: OP_SNAP_PREP, hold: HOLD_NONE,     jump: 1'b0, target: PC_TAKE};
      4'd4: cw = '{op: OP_ACC,       hold: HOLD_NONE,     jump: 1'b0, target: PC_TAKE};
      4'd5: cw = '{op: OP_ITER,      hold: HOLD_DIV_BUSY, jump: 1'b0, target: PC_TAKE};
      4'd6: cw = '{op: OP_CLAMP,     hold: HOLD_NONE,     jump: 1'b0, target: PC_TAKE};
      4'd7: cw = '{op: OP_ITER,      hold: HOLD_DIV_BUSY, jump: 1'b0, target: PC_TAKE};
      4'd8: cw = '{op: OP_EMIT,      hold: HOLD_OUT_BUSY, jump: 1'b1, target: PC_TAKE};
      default: cw = '{op: OP_NOP, hold: HOLD_NONE, jump: 1'b1, target: PC_TAKE};
    endcase
    return cw;
  endfunction

endpackage

FILE: src/fstb_divider.sv
// Restoring serial divider, one quotient bit per cycle.
module fstb_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  fstb_pkg::div_ctrl_t           ctrl,
  input  logic [fstb_pkg::DIV_NUM_W-1:0] num_init,
  input  logic [fstb_pkg::DIV_DEN_W-1:0] rem_init,
  input  logic [fstb_pkg::DIV_DEN_W-1:0] den_init,
  output logic [fstb_pkg::DIV_NUM_W-1:0] quo,
  output logic [fstb_pkg::DIV_DEN_W-1:0] rem,
  output fstb_pkg::div_stat_t           stat
);
  import fstb_pkg::*;

  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_NUM_W-1:0] num;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W:0]   trial;

  // Bring down the next numerator bit and try the subtraction.
  assign shifted = {rem, num[DIV_NUM_W-1]};
  assign trial   = shifted - {1'b0, den};

  assign stat.busy = (cnt != '0);
  assign stat.last = (cnt == DIV_CNT_W'(1));

  // Counter is control state and is reset; the data registers have no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.load) begin
      cnt <= ctrl.iters;
    end else if (cnt != '0) begin
      cnt <= cnt - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      num <= num_init;
      rem <= rem_init;
      den <= den_init;
      quo <= '0;
    end else if (cnt != '0) begin
      num <= {num[DIV_NUM_W-2:0], 1'b0};
      if (!trial[DIV_DEN_W]) begin
        rem <= trial[DIV_DEN_W-1:0];
        quo <= {quo[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DIV_DEN_W-1:0];
        quo <= {quo[DIV_NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: src/fixed_step_time_bank.sv
// Fixed step time bank: a microcoded sequencer turns frame durations into step counts.
// Each frame beat yields one result beat: the number of fixed steps to run and the
// Q0.16 interpolation fraction of the banked leftover. The frame is rounded to whole
// steps, snapped to them when within tolerance, added to the bank, split into steps
// (clamped to max_steps, which clears the bank) and the remainder divided into alpha.
// All three divisions run on one shared restoring divider at one bit per cycle, in turn,
// and no new frame is taken until the last result is emitted. A new frame is accepted
// while the previous result is still waiting in the output register; the result step
// holds only if that register is still occupied. Configuration writes are always
// ready and take effect at once.
module fixed_step_time_bank (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fstb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fstb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              frame_valid,
  output logic                              frame_stall,
  input  logic [fstb_pkg::FRAME_W-1:0]      frame_ticks,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [fstb_pkg::COUNT_W-1:0]      steps_due,
  output logic [fstb_pkg::ALPHA_W-1:0]      alpha_q16
);
  import fstb_pkg::*;

  localparam int WT_W   = FRAME_W + 1;
  localparam int PROD_W = STEP_W + TOL_W;

  // Configuration registers.
  logic [STEP_W-1:0] step_ticks;
  logic [MAXS_W-1:0] max_steps;
  logic [TOL_W-1:0]  snap_tol;

  // Sequencer.
  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ctrl_word_t      cw;
  logic            hold;
  logic            frame_fire;
  logic            out_busy;

  // Datapath registers.
  logic [FRAME_W-1:0] frame;
  logic [STEP_W-1:0]  bank;
  logic [STEP_W-1:0]  diff;
  logic [WT_W-1:0]    whole_t;
  logic               whole_nz;
  logic [PROD_W-1:0]  tol_prod;
  logic [COUNT_W-1:0] count_hold;

  // Datapath logic.
  logic [STEP_W-1:0]    period;
  logic [DIV_DEN_W-1:0] period_x;
  logic [DIV_DEN_W-1:0] dsig;
  logic                 rem_ge;
  logic                 snap;
  logic [WT_W-1:0]      frame_eff;
  logic [DIV_NUM_W-1:0] acc;
  logic                 clamp;
  logic [STEP_W-1:0]    bank_next;

  // Divider connections.
  div_ctrl_t            div_ctrl;
  div_stat_t            div_stat;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_rem0;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] div_quo;
  logic [DIV_DEN_W-1:0] div_rem;

  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_ticks <= STEP_TICKS_RESET;
      max_steps  <= MAX_STEPS_RESET;
      snap_tol   <= SNAP_TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEP_TICKS: step_ticks <= cfg_data[STEP_W-1:0];
        REG_MAX_STEPS:  max_steps  <= cfg_data[MAXS_W-1:0];
        REG_SNAP_TOL:   snap_tol   <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero period behaves as one tick.
  assign period   = (step_ticks == '0) ? STEP_W'(1) : step_ticks;
  assign period_x = {1'b0, period};

  // Control word fetch and handshake status.
  assign cw          = fstb_rom(pc);
  assign frame_stall = rst || (cw.op != OP_TAKE);
  assign frame_fire  = frame_valid && !frame_stall;
  assign out_busy    = result_valid && result_stall;

  // Hold on the current step, jump, or fall through.
  always_comb begin
    unique case (cw.hold)
      HOLD_NONE:     hold = 1'b0;
      HOLD_NO_INPUT: hold = !frame_fire;
      HOLD_DIV_BUSY: hold = div_stat.busy && !div_stat.last;
      HOLD_OUT_BUSY: hold = out_busy;
      default:       hold = 1'b0;
    endcase
    if (hold) begin
      pc_next = pc;
    end else if (cw.jump) begin
      pc_next = cw.target;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  // Distance of the frame from the rounded step count: (r - P) / 2, sign kept apart.
  assign rem_ge = (div_rem >= period_x);
  assign dsig   = rem_ge ? (div_rem - period_x) : (period_x - div_rem);

  // Snap decision and banked sum.
  assign snap      = whole_nz && ({diff, 8'b0} <= {1'b0, tol_prod});
  assign frame_eff = snap ? whole_t : {1'b0, frame};
  assign acc       = DIV_NUM_W'(bank) + DIV_NUM_W'(frame_eff);

  // Step count clamp; the bank empties when clamped.
  assign clamp     = (div_quo > DIV_NUM_W'(max_steps));
  assign bank_next = clamp ? '0 : div_rem[STEP_W-1:0];

  // Divider loads for the three divisions.
  always_comb begin
    div_ctrl = '{load: 1'b0, iters: DIV_ITERS_LONG};
    div_num  = '0;
    div_rem0 = '0;
    div_den  = period_x;
    unique case (cw.op)
      OP_DIV_ROUND: begin
        div_ctrl.load = 1'b1;
        div_num       = DIV_NUM_W'({frame, 1'b0}) + DIV_NUM_W'(period);
        div_den       = {period, 1'b0};
      end
      OP_ACC: begin
        div_ctrl.load = 1'b1;
        div_num       = acc;
      end
      OP_CLAMP: begin
        div_ctrl.load  = 1'b1;
        div_ctrl.iters = DIV_ITERS_ALPHA;
        div_rem0       = {1'b0, bank_next};
      end
      default: ;
    endcase
  end

  fstb_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .num_init (div_num),
    .rem_init (div_rem0),
    .den_init (div_den),
    .quo      (div_quo),
    .rem      (div_rem),
    .stat     (div_stat)
  );

  // Step counter, bank and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= PC_TAKE;
      bank         <= '0;
      result_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (cw.op == OP_CLAMP) begin
        bank <= bank_next;
      end
      if (cw.op == OP_EMIT && !out_busy) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Working registers of the datapath.
  always_ff @(posedge clk) begin
    unique case (cw.op)
      OP_TAKE: begin
        if (frame_fire) begin
          frame <= frame_ticks;
        end
      end
      OP_SNAP_PREP: begin
        diff     <= dsig[STEP_W:1];
        whole_nz <= (div_quo != '0);
        whole_t  <= rem_ge ? ({1'b0, frame} - WT_W'(dsig[STEP_W:1]))
                           : ({1'b0, frame} + WT_W'(dsig[STEP_W:1]));
        tol_prod <= PROD_W'(snap_tol) * PROD_W'(period);
      end
      OP_CLAMP: begin
        count_hold <= clamp ? max_steps : div_quo[COUNT_W-1:0];
      end
      OP_EMIT: begin
        if (!out_busy) begin
          steps_due <= count_hold;
          alpha_q16 <= div_quo[ALPHA_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: src/fstb_checker.sv
// Port-level checker for the fixed step time bank, bound to the top level.
`include "fixed_step_time_bank_macros.svh"

module fstb_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [fstb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input logic [fstb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input logic                              frame_valid,
  input logic                              frame_stall,
  input logic                              result_valid,
  input logic                              result_stall,
  input logic [fstb_pkg::COUNT_W-1:0]      steps_due,
  input logic [fstb_pkg::ALPHA_W-1:0]      alpha_q16
);
  import fstb_pkg::*;

  logic [1:0]                 pending;
  logic [MAXS_W-1:0]          max_shadow;
  logic                       in_beat;
  logic                       out_beat;
  logic                       out_wait;
  logic                       count_ok;
  logic [COUNT_W+ALPHA_W-1:0] result_word;

  assign in_beat  = frame_valid && !frame_stall;
  assign out_beat = result_valid && !result_stall;
  assign out_wait = result_valid && result_stall;

  // Result fields as one word, and the step limit check as seen on the ports.
  assign result_word = {steps_due, alpha_q16};
  assign count_ok    = !result_valid || (steps_due <= max_shadow);

  // Frames accepted whose result beat has not gone out yet.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_beat) - 2'(out_beat);
    end
  end

  // Copy of the step limit as written through the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_shadow <= MAX_STEPS_RESET;
    end else if (cfg_valid && cfg_ready && cfg_index == REG_MAX_STEPS) begin
      max_shadow <= cfg_data[MAXS_W-1:0];
    end
  end

  `FSTB_ASSERT_ALWAYS(a_no_phantom_result, !result_valid || pending != 2'd0, "result without frame")
  `FSTB_ASSERT_ALWAYS(a_pending_bound, pending <= 2'd2, "more than two frames in flight")
  `FSTB_ASSERT_ALWAYS(a_count_limit, count_ok, "step count over limit")
  `FSTB_ASSERT_NEXT(a_result_held, out_wait, result_valid && $stable(result_word), "held beat changed")

endmodule

bind fixed_step_time_bank fstb_checker u_fstb_checker (.*);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the fixed step time bank, driven by directed and random frames.
module tb_top;
  import fstb_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_FRAMES = 82;
  localparam logic [63:0] FRAME_MAX = 64'hFF_FFFF;

  // One result beat: steps granted and interpolation fraction.
  typedef struct packed {
    logic [COUNT_W-1:0] steps;
    logic [ALPHA_W-1:0] alpha;
  } step_grant_t;

  // Tracks the register file and the banked ticks, and holds the grants still owed.
  class time_bank_board;
    logic [STEP_W-1:0] period_reg;
    logic [MAXS_W-1:0] max_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic [STEP_W-1:0] bank;
    step_grant_t       grants_due[$];
    int                errors;

    function new();
      period_reg = STEP_TICKS_RESET;
      max_reg    = MAX_STEPS_RESET;
      tol_reg    = SNAP_TOL_RESET;
      bank       = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_STEP_TICKS: period_reg = data[STEP_W-1:0];
        REG_MAX_STEPS:  max_reg = data[MAXS_W-1:0];
        REG_SNAP_TOL:   tol_reg = data[TOL_W-1:0];
        default: ;
      endcase
    endfunction

    // Rounds, snaps and banks one frame, then queues the grant it earns.
    function void note_frame(logic [FRAME_W-1:0] frame);
      logic [63:0] p, f, whole, whole_t, diff, acc, count, left, frac;
      step_grant_t g;
      p = (period_reg == '0) ? 64'd1 : 64'(period_reg);
      f = 64'(frame);
      whole = (2 * f + p) / (2 * p);
      whole_t = whole * p;
      diff = (f >= whole_t) ? (f - whole_t) : (whole_t - f);
      if (whole >= 1 && diff * 256 <= 64'(tol_reg) * p)
        f = whole_t;
      acc = 64'(bank) + f;
      count = acc / p;
      if (count > 64'(max_reg)) begin
        count = 64'(max_reg);
        left = '0;
      end else begin
        left = acc - count * p;
      end
      bank = left[STEP_W-1:0];
      frac = (64'(bank) << 16) / p;
      g.steps = count[COUNT_W-1:0];
      g.alpha = frac[ALPHA_W-1:0];
      grants_due.push_back(g);
    endfunction

    function void check_result(logic [COUNT_W-1:0] steps, logic [ALPHA_W-1:0] alpha);
      step_grant_t g;
      if (grants_due.size() == 0) begin
        errors++;
        $error("result beat with no frame pending: steps_due %0d alpha_q16 %0d", steps, alpha);
        return;
      end
      g = grants_due.pop_front();
      if (steps !== g.steps) begin
        errors++;
        $error("steps_due: expected %0d, actual %0d", g.steps, steps);
      end
      if (alpha !== g.alpha) begin
        errors++;
        $error("alpha_q16: expected %0d, actual %0d", g.alpha, alpha);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   frame_valid = 1'b0;
  logic                   frame_stall;
  logic [FRAME_W-1:0]     frame_ticks = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic [COUNT_W-1:0]     steps_due;
  logic [ALPHA_W-1:0]     alpha_q16;

  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  bit             hold_off_req = 1'b0;
  time_bank_board board = new();

  fixed_step_time_bank DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame_ticks  (frame_ticks),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .steps_due    (steps_due),
    .alpha_q16    (alpha_q16)
  );

  always #4 clk = ~clk;

  // Writes one register and mirrors it once the beat is taken.
  task automatic program_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one frame beat after a random gap and records it when accepted.
  task automatic send_frame(input logic [FRAME_W-1:0] f);
    int gap;
    gap = 0;
    if (send_idle_pct > 0) begin
      if ($urandom_range(99) < 4)
        gap = $urandom_range(90, 1);
      else
        while ($urandom_range(99) < send_idle_pct) gap++;
    end
    if (gap > 0) begin
      frame_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_valid <= 1'b1;
    frame_ticks <= f;
    do @(posedge clk); while (frame_stall);
    board.note_frame(f);
  endtask

  // Stops offering frames and waits until every owed grant has come back.
  task automatic settle();
    frame_valid <= 1'b0;
    @(posedge clk);
    while (board.grants_due.size() != 0) @(posedge clk);
  endtask

  // Frames clustered around step multiples and snap edges, plus ties, raw noise, small frames and the extremes.
  function automatic logic [FRAME_W-1:0] pick_frame();
    logic [63:0] p, whole, reach, base, off, f;
    int kind;
    p = (board.period_reg == '0) ? 64'd1 : 64'(board.period_reg);
    kind = $urandom_range(9);
    whole = 64'($urandom_range(int'(board.max_reg) + 2));
    reach = (64'(board.tol_reg) * p) / 256 + 2;
    case (kind)
      0, 1, 2, 3: begin
        base = whole * p;
        off = 64'($urandom()) % (2 * reach + 1);
        f = (base + off < reach) ? 64'd0 : base + off - reach;
      end
      4: f = whole * p + p / 2 + 64'($urandom_range(1));
      5: f = 64'($urandom()) & FRAME_MAX;
      6, 7: f = 64'($urandom()) % ((whole + 1) * p);
      8: f = 64'($urandom_range(255));
      default: f = $urandom_range(1) ? FRAME_MAX : 64'd0;
    endcase
    if (f > FRAME_MAX)
      f = FRAME_MAX;
    return f[FRAME_W-1:0];
  endfunction

  // Result side: checks accepted beats and decides the stall for the next edge.
  initial begin : result_sink
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall)
        board.check_result(steps_due, alpha_q16);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = HOLD_OFF_CYCLES;
      end
      if (hold > 0) begin
        result_stall <= 1'b1;
        hold--;
      end else if (recv_idle_pct > 0 && $urandom_range(99) < 3) begin
        hold = $urandom_range(80, 1);
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    logic [STEP_W-1:0] step_val;
    logic [MAXS_W-1:0] max_val;
    logic [TOL_W-1:0]  tol_val;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: zero frame, exact step, both sides of each snap window edge, both
    // sides of the half step, exactly max_steps and a saturated frame that clamps.
    send_frame(24'd0);
    send_frame(24'd1);
    send_frame(24'd16667);
    send_frame(24'd19141);
    send_frame(24'd19142);
    send_frame(24'd14193);
    send_frame(24'd14192);
    send_frame(24'd8333);
    send_frame(24'd8334);
    send_frame(24'd133336);
    send_frame(24'hFFFFFF);
    send_frame(24'd25000);

    // Longest period, widest grant and widest snap window.
    settle();
    program_reg(REG_STEP_TICKS, 20'hFFFFF);
    program_reg(REG_MAX_STEPS, 20'h000FF);
    program_reg(REG_SNAP_TOL, 20'h0007F);
    send_frame(24'hFFFFFF);
    send_frame(24'h800000);
    send_frame(24'h555555);
    send_frame(24'hAAAAAA);
    send_frame(24'd524288);

    // Zero period counts as one tick; zero max_steps grants nothing and clears the bank.
    // Upper data bits are set to show they are dropped, and the unused index is ignored.
    settle();
    program_reg(REG_STEP_TICKS, 20'h00000);
    program_reg(REG_MAX_STEPS, 20'hFFF00);
    program_reg(REG_SNAP_TOL, 20'hFFF80);
    program_reg(REG_UNUSED, 20'h5A5A5);
    send_frame(24'd0);
    send_frame(24'd5);
    send_frame(24'd3);

    // One tick period: the grant reaches 255 exactly and then clamps.
    settle();
    program_reg(REG_STEP_TICKS, 20'd1);
    program_reg(REG_MAX_STEPS, 20'd255);
    send_frame(24'd255);
    send_frame(24'd256);
    send_frame(24'd0);

    // Random phases, each with its own settings and idle pattern.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      case (phase)
        0: begin
          step_val = STEP_W'($urandom_range(64, 1));
          max_val = MAXS_W'($urandom_range(255, 200));
          tol_val = 7'd127;
        end
        1: begin
          step_val = STEP_W'($urandom_range(30000, 10000));
          max_val = MAXS_W'($urandom_range(16, 1));
          tol_val = TOL_W'($urandom_range(127));
        end
        3: begin
          step_val = 20'hFFFFF;
          max_val = 8'd1;
          tol_val = 7'd0;
        end
        4: begin
          step_val = STEP_W'($urandom_range(4000, 100));
          max_val = MAXS_W'($urandom_range(255));
          tol_val = TOL_W'($urandom_range(127));
        end
        5: begin
          step_val = STEP_W'($urandom_range(20'hFFFFF, 1));
          max_val = 8'd255;
          tol_val = 7'd127;
        end
        6: begin
          step_val = STEP_W'($urandom_range(16, 1));
          max_val = MAXS_W'($urandom_range(3));
          tol_val = TOL_W'($urandom_range(127));
        end
        7: begin
          step_val = STEP_W'($urandom_range(2000, 1));
          max_val = MAXS_W'($urandom_range(255));
          tol_val = TOL_W'($urandom_range(127));
        end
        default: begin
          step_val = STEP_W'($urandom_range(20'hFFFFF, 1));
          max_val = MAXS_W'($urandom_range(255));
          tol_val = TOL_W'($urandom_range(127));
        end
      endcase
      program_reg(REG_STEP_TICKS, step_val);
      program_reg(REG_MAX_STEPS, {12'($urandom()), max_val});
      program_reg(REG_SNAP_TOL, {13'($urandom()), tol_val});

      if (phase < 3) begin
        send_idle_pct = 15;
        recv_idle_pct = 70;
      end else if (phase < 6) begin
        send_idle_pct = 70;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      for (int n = 0; n < PHASE_FRAMES; n++) begin
        // Long result hold-off while frames keep coming, so the input backs up.
        if ((phase == 1 && n == 20) || (phase == 6 && n == 10))
          hold_off_req = 1'b1;
        // Sender pause mid-phase until every grant is back.
        if (phase == 4 && n == 40)
          settle();
        send_frame(pick_frame());
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.grants_due.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #20ms;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
